// ===== hw/rtl/nalsp_pkg.sv =====
// Shared types and constants for the Annex B NAL unit splitter.
// Used by nalsp_front, nalsp_queue, nalsp_back and the top level.
package nalsp_pkg;

    localparam logic [4:0] NAL_TYPE_MASK  = 5'h1f;
    localparam logic [4:0] NAL_TYPE_AUD   = 5'h09;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;
    localparam logic [7:0] BYTE_START     = 8'h01;
    localparam int         WORDS_PER_ITEM = 4;
    localparam int         QUEUE_DEPTH    = 4;

    // Up to four output words produced by one input byte, all of one unit.
    typedef struct packed {
        logic [WORDS_PER_ITEM-1:0][7:0] bytes;
        logic [1:0]                     last_idx;
        logic                           first;
        logic                           last;
        logic [4:0]                     unit_type;
    } entry_t;

endpackage

// ===== hw/rtl/annexb_nal_unit_splitter.sv =====
// Annex B NAL unit splitter, top level.
// Instantiates nalsp_front, nalsp_queue and nalsp_back; uses nalsp_pkg.
//
// Input channel (s_*): one stream byte per handshake, s_end_of_stream on the
// final byte. Output channel (m_*): NAL payload bytes with start codes
// removed, header byte flagged first, final byte flagged last, and the
// unit's 5-bit type on every word.
// cfg_we/cfg_wdata write drop_delimiters (1 = drop access unit delimiters).
// A byte is held back until the following bytes show whether it ends its
// unit, so each word leaves after later input bytes. Words released by an
// accepted byte are written into the entry queue and then loaded into the
// back end's output register before they show on m_*. The front end takes
// one byte per cycle while the queue has room; the back end sends one word
// per cycle while m_ready is high. A byte releases up to four words, which
// the back end sends one at a time; the entry queue absorbs such bursts.
// Reset: drop_delimiters = 1, parser searching for a start code, queue and
// output empty. When m_ready is low the output word holds, the queue fills,
// and s_ready drops once the queue is full.
module annexb_nal_unit_splitter #(
    parameter int QUEUE_DEPTH = nalsp_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_stream,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_nal_byte,
    output logic       m_first_of_unit,
    output logic       m_last_of_unit,
    output logic [4:0] m_unit_type
);

    logic              push_valid;
    logic              push_ready;
    nalsp_pkg::entry_t push_entry;
    logic              pop_valid;
    logic              pop;
    nalsp_pkg::entry_t pop_entry;

    nalsp_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_stream (s_end_of_stream),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_entry      (push_entry)
    );

    nalsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_entry  (pop_entry)
    );

    nalsp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pop_valid       (pop_valid),
        .pop             (pop),
        .pop_entry       (pop_entry),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_nal_byte      (m_nal_byte),
        .m_first_of_unit (m_first_of_unit),
        .m_last_of_unit  (m_last_of_unit),
        .m_unit_type     (m_unit_type)
    );

endmodule

// ===== hw/rtl/nalsp_front.sv =====
// Front end: accepts stream bytes, tracks start codes and the open unit,
// and packs the words each byte releases into one queue entry. Uses nalsp_pkg.
module nalsp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_in_byte,
    input  logic                s_end_of_stream,
    output logic                push_valid,
    input  logic                push_ready,
    output nalsp_pkg::entry_t   push_entry
);

    logic       drop_reg;
    logic [1:0] lc_reg, lc_next;
    logic       pv_reg, pv_next;
    logic [7:0] pb_reg, pb_next;
    logic       ins_reg, ins_next;
    logic       hdr_reg, hdr_next;
    logic [4:0] ty_reg, ty_next;
    logic       sp_reg, sp_next;
    logic [2:0] n;
    logic       accept;

    assign s_ready    = push_ready;
    assign accept     = s_valid & s_ready;
    assign push_valid = accept & (n != 3'd0);

    always_comb begin
        logic [7:0] pbyte;
        lc_next    = lc_reg;
        pv_next    = pv_reg;
        pb_next    = pb_reg;
        ins_next   = ins_reg;
        hdr_next   = hdr_reg;
        ty_next    = ty_reg;
        sp_next    = sp_reg;
        n          = 3'd0;
        push_entry = '0;
        pbyte      = nalsp_pkg::BYTE_ZERO;

        if (s_in_byte == nalsp_pkg::BYTE_ZERO) begin
            if (lc_reg < 2'd2) begin
                lc_next = lc_reg + 2'd1;
            end else if (lc_reg == 2'd2) begin
                lc_next = 2'd3;
                // three zeros: close the open unit
                if (ins_next && pv_next) begin
                    if (!sp_next) begin
                        push_entry.bytes[n[1:0]] = pb_next;
                        if (n == 3'd0) push_entry.first = hdr_next;
                        push_entry.last = 1'b1;
                        n = n + 3'd1;
                    end
                    hdr_next = 1'b0;
                end
                ins_next = 1'b0;
                pv_next  = 1'b0;
                pb_next  = nalsp_pkg::BYTE_ZERO;
            end
        end else if (s_in_byte == nalsp_pkg::BYTE_START && lc_reg >= 2'd2) begin
            if (ins_next && pv_next) begin
                if (!sp_next) begin
                    push_entry.bytes[n[1:0]] = pb_next;
                    if (n == 3'd0) push_entry.first = hdr_next;
                    push_entry.last = 1'b1;
                    n = n + 3'd1;
                end
                hdr_next = 1'b0;
            end
            pv_next  = 1'b0;
            pb_next  = nalsp_pkg::BYTE_ZERO;
            ins_next = 1'b1;
            hdr_next = 1'b1;
            sp_next  = 1'b0;
            lc_next  = 2'd0;
        end else begin
            if (lc_reg != 2'd3) begin
                // held zeros first, then this byte
                for (int j = 0; j < 3; j++) begin
                    if (2'(j) <= lc_reg) begin
                        pbyte = (2'(j) == lc_reg) ? s_in_byte : nalsp_pkg::BYTE_ZERO;
                        if (ins_next) begin
                            if (pv_next) begin
                                if (!sp_next) begin
                                    push_entry.bytes[n[1:0]] = pb_next;
                                    if (n == 3'd0) push_entry.first = hdr_next;
                                    n = n + 3'd1;
                                end
                                hdr_next = 1'b0;
                            end else begin
                                ty_next = pbyte[4:0] & nalsp_pkg::NAL_TYPE_MASK;
                                sp_next = drop_reg && (ty_next == nalsp_pkg::NAL_TYPE_AUD);
                            end
                            pb_next = pbyte;
                            pv_next = 1'b1;
                        end
                    end
                end
            end
            lc_next = 2'd0;
        end

        if (s_end_of_stream) begin
            if (ins_next && pv_next) begin
                if (!sp_next) begin
                    push_entry.bytes[n[1:0]] = pb_next;
                    if (n == 3'd0) push_entry.first = hdr_next;
                    push_entry.last = 1'b1;
                    n = n + 3'd1;
                end
                hdr_next = 1'b0;
            end
        end

        push_entry.unit_type = ty_next;
        push_entry.last_idx  = 2'(n - 3'd1);

        if (s_end_of_stream) begin
            lc_next  = 2'd0;
            pv_next  = 1'b0;
            pb_next  = nalsp_pkg::BYTE_ZERO;
            ins_next = 1'b0;
            hdr_next = 1'b0;
            ty_next  = 5'd0;
            sp_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_reg <= 1'b1;
            lc_reg   <= 2'd0;
            pv_reg   <= 1'b0;
            pb_reg   <= nalsp_pkg::BYTE_ZERO;
            ins_reg  <= 1'b0;
            hdr_reg  <= 1'b0;
            ty_reg   <= 5'd0;
            sp_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                drop_reg <= cfg_wdata;
            end
            if (accept) begin
                lc_reg  <= lc_next;
                pv_reg  <= pv_next;
                pb_reg  <= pb_next;
                ins_reg <= ins_next;
                hdr_reg <= hdr_next;
                ty_reg  <= ty_next;
                sp_reg  <= sp_next;
            end
        end
    end

    // a start code never leaves a held zero behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_in_byte == nalsp_pkg::BYTE_START && lc_reg >= 2'd2 |=> lc_reg == 2'd0)
        else $error("lookahead not cleared after start code");

    // a held payload byte only exists inside an open unit
    assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |-> ins_reg)
        else $error("held byte outside a unit");

endmodule

// ===== hw/rtl/nalsp_queue.sv =====
// Small entry queue between the parser front end and the output serializer.
// Flop array, depth a power of two of at least 2. Uses nalsp_pkg.
module nalsp_queue #(
    parameter int DEPTH = nalsp_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  nalsp_pkg::entry_t   push_entry,
    output logic                pop_valid,
    input  logic                pop,
    output nalsp_pkg::entry_t   pop_entry
);

    localparam int AW = $clog2(DEPTH);

    nalsp_pkg::entry_t mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [AW:0]       count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers diverged while empty");

endmodule

// ===== hw/rtl/nalsp_back.sv =====
// Back end: unpacks queue entries into one output word per handshake.
// Uses nalsp_pkg.
module nalsp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop,
    input  nalsp_pkg::entry_t   pop_entry,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_nal_byte,
    output logic                m_first_of_unit,
    output logic                m_last_of_unit,
    output logic [4:0]          m_unit_type
);

    nalsp_pkg::entry_t cur_reg;
    logic              cur_v_reg;
    logic [1:0]        idx_reg;
    logic              take;
    logic              done;
    logic              load;

    assign take = cur_v_reg & m_ready;
    assign done = take && (idx_reg == cur_reg.last_idx);
    assign load = pop_valid && (!cur_v_reg || done);
    assign pop  = load;

    assign m_valid         = cur_v_reg;
    assign m_nal_byte      = cur_reg.bytes[idx_reg];
    assign m_first_of_unit = cur_reg.first && (idx_reg == 2'd0);
    assign m_last_of_unit  = cur_reg.last && (idx_reg == cur_reg.last_idx);
    assign m_unit_type     = cur_reg.unit_type;

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= pop_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_v_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            cur_v_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (done) begin
            cur_v_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (take) begin
            idx_reg   <= idx_reg + 2'd1;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cur_v_reg |-> idx_reg <= cur_reg.last_idx)
        else $error("word index past end of entry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        take && !done |=> cur_v_reg && idx_reg == $past(idx_reg) + 2'd1)
        else $error("word index did not advance");

endmodule
